>>> rtl/core/itra_pkg.sv
// itra_pkg: shared types, constants and the digit-to-ascii function for the
// integer-to-text converter
// depends on nothing

package itra_pkg;

  localparam int unsigned RADIX_W = 6;
  localparam int unsigned CHAR_W  = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_EMIT
  } itra_state_t;

  // status of the bit-serial divider
  typedef struct packed {
    logic               busy;
    logic               done;
    logic [RADIX_W-1:0] rem;
  } div_stat_t;

  // digit value to ascii, '0'-'9' then 'A'-'Z'; anything else reads as '0'
  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    c = CHAR_ZERO;
    if (d inside {[6'd0:6'd9]}) begin
      c = CHAR_ZERO + {2'b00, d};
    end else if (d inside {[6'd10:6'd35]}) begin
      c = CHAR_A + {2'b00, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

>>> rtl/core/int_to_radix_ascii.sv
// int_to_radix_ascii: top level, sequencer around the divider and digit store
// depends on itra_pkg, itra_divider, itra_digit_mem
//
// Usage
//   Config: cfg_we writes cfg_radix (reset 10); values below 2 act as 2 and
//   above 36 act as 36. Write only while busy is low.
//   Input: an item is taken at a rising edge with start high and busy low.
//   Radix ten with a negative value gives '-' and the magnitude; any other
//   radix converts the raw bits as unsigned.
//   Output: one character per out_valid strobe, most significant first,
//   out_last on the final one. The receiver cannot stall; each strobe lasts
//   exactly one cycle.
//   Sequence: each digit comes from the bit-serial divider, which sets the
//   pace; then comes the sign slot, and each character passes through a
//   store read, then the output register. busy falls in the cycle of the
//   last strobe of an item, so the next item can be taken there.
//   Reset: synchronous, active low; returns idle with radix ten. The digit
//   store needs no clearing.

module int_to_radix_ascii #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned MAX_DIGITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [itra_pkg::RADIX_W-1:0]  cfg_radix,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_BITS-1:0]  in_value,
  output logic                          out_valid,
  output logic [itra_pkg::CHAR_W-1:0]   out_char,
  output logic                          out_last
);

  localparam int unsigned CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int unsigned ADDR_W = $clog2(MAX_DIGITS);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_DIGITS);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  itra_pkg::itra_state_t state_r, state_nxt;

  logic [itra_pkg::RADIX_W-1:0] radix_r, radix_nxt;
  logic [itra_pkg::RADIX_W-1:0] base;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [CNT_W-1:0]             idx_r, idx_nxt;
  logic                         neg_r, neg_nxt;
  logic                         accept;
  logic                         in_neg;
  logic [VALUE_BITS-1:0]        in_mag;

  logic                         div_start;
  logic [VALUE_BITS-1:0]        div_dividend;
  logic [VALUE_BITS-1:0]        div_quot;
  itra_pkg::div_stat_t          div_stat;

  logic                         mem_we;
  logic [ADDR_W-1:0]            mem_rd_addr;
  logic [itra_pkg::RADIX_W-1:0] mem_rd_data;
  logic [CNT_W-1:0]             idx_dec;

  logic                         out_valid_r, out_valid_nxt;
  logic [itra_pkg::CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic                         out_last_r, out_last_nxt;

  // radix register and its clamped value
  always_comb begin
    radix_nxt = cfg_we ? cfg_radix : radix_r;
    if (radix_r < itra_pkg::RADIX_MIN) begin
      base = itra_pkg::RADIX_MIN;
    end else if (radix_r > itra_pkg::RADIX_MAX) begin
      base = itra_pkg::RADIX_MAX;
    end else begin
      base = radix_r;
    end
  end

  // item acceptance and sign handling
  assign busy    = (state_r != itra_pkg::ST_IDLE);
  assign accept  = start && !busy;
  assign in_neg  = (base == itra_pkg::RADIX_DEC) && in_value[VALUE_BITS-1];
  assign in_mag  = in_neg ? (VALUE_BITS'(0) - VALUE_BITS'(in_value))
                          : VALUE_BITS'(in_value);

  // next state and sequencer registers
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    neg_nxt      = neg_r;
    div_start    = 1'b0;
    div_dividend = in_mag;
    mem_we       = 1'b0;
    case (state_r)
      itra_pkg::ST_IDLE: begin
        if (accept) begin
          neg_nxt   = in_neg;
          cnt_nxt   = '0;
          div_start = 1'b1;
          state_nxt = itra_pkg::ST_DIV;
        end
      end
      itra_pkg::ST_DIV: begin
        if (div_stat.done) begin
          mem_we  = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          if (div_quot == '0 || (cnt_r + 1'b1) == CNT_FULL) begin
            idx_nxt   = cnt_r + 1'b1;
            state_nxt = itra_pkg::ST_SIGN;
          end else begin
            div_start    = 1'b1;
            div_dividend = div_quot;
          end
        end
      end
      itra_pkg::ST_SIGN: begin
        state_nxt = itra_pkg::ST_READ;
      end
      itra_pkg::ST_READ: begin
        state_nxt = itra_pkg::ST_EMIT;
      end
      itra_pkg::ST_EMIT: begin
        idx_nxt   = idx_dec;
        state_nxt = (idx_r == CNT_ONE) ? itra_pkg::ST_IDLE : itra_pkg::ST_READ;
      end
      default: begin
        state_nxt = itra_pkg::ST_IDLE;
      end
    endcase
  end

  // output register next values
  always_comb begin
    out_valid_nxt = 1'b0;
    out_char_nxt  = itra_pkg::digit_char(mem_rd_data);
    out_last_nxt  = 1'b0;
    case (state_r)
      itra_pkg::ST_SIGN: begin
        out_valid_nxt = neg_r;
        out_char_nxt  = itra_pkg::CHAR_MINUS;
      end
      itra_pkg::ST_EMIT: begin
        out_valid_nxt = 1'b1;
        out_last_nxt  = (idx_r == CNT_ONE);
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // digits are read from the top of the store down
  assign idx_dec     = idx_r - 1'b1;
  assign mem_rd_addr = idx_dec[ADDR_W-1:0];

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itra_pkg::ST_IDLE;
      radix_r     <= itra_pkg::RADIX_RESET;
      cnt_r       <= '0;
      idx_r       <= '0;
      neg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      radix_r     <= radix_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      neg_r       <= neg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  // bit-serial divider
  itra_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (base),
    .quotient (div_quot),
    .stat     (div_stat)
  );

  // digit store, least significant digit at address zero
  itra_digit_mem #(
    .DEPTH (MAX_DIGITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (cnt_r[ADDR_W-1:0]),
    .wr_data (div_stat.rem),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // a strobe only follows a sign or emit cycle
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == itra_pkg::ST_SIGN ||
                     $past(state_r) == itra_pkg::ST_EMIT))
    else $error("out_valid without sign or emit cycle");

  // the digit count never passes the store depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("digit count beyond store depth");

  // nothing follows the last character of an item
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |=> !out_valid_r)
    else $error("character after last");

  // while dividing the divider is running or just finished
  a_div_alive: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == itra_pkg::ST_DIV) |-> (div_stat.busy || div_stat.done))
    else $error("divide state with idle divider");

endmodule

>>> rtl/core/itra_divider.sv
// itra_divider: restoring divider, one quotient bit per cycle, by a 6-bit radix
// depends on itra_pkg

module itra_divider #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [VALUE_BITS-1:0]          dividend,
  input  logic [itra_pkg::RADIX_W-1:0]   divisor,
  output logic [VALUE_BITS-1:0]          quotient,
  output itra_pkg::div_stat_t            stat
);

  localparam int unsigned CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_BITS - 1);

  logic [VALUE_BITS-1:0]          quot_r, quot_nxt;
  logic [itra_pkg::RADIX_W-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  logic                           run_r, run_nxt;
  logic                           done_r, done_nxt;
  logic [itra_pkg::RADIX_W:0]     rem_sh;
  logic [itra_pkg::RADIX_W:0]     rem_sub;
  logic                           ge;

  // one shift-compare-subtract step
  always_comb begin
    rem_sh  = {rem_r, quot_r[VALUE_BITS-1]};
    ge      = rem_sh >= {1'b0, divisor};
    rem_sub = rem_sh - {1'b0, divisor};
  end

  // next values
  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      quot_nxt = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      quot_nxt = {quot_r[VALUE_BITS-2:0], ge};
      rem_nxt  = ge ? rem_sub[itra_pkg::RADIX_W-1:0] : rem_sh[itra_pkg::RADIX_W-1:0];
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
  end

  assign quotient  = quot_r;
  assign stat.busy = run_r;
  assign stat.done = done_r;
  assign stat.rem  = rem_r;

endmodule

>>> rtl/core/itra_digit_mem.sv
// itra_digit_mem: digit store, one write and one registered read port
// depends on itra_pkg

module itra_digit_mem #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  logic [itra_pkg::RADIX_W-1:0]  wr_data,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr,
  output logic [itra_pkg::RADIX_W-1:0]  rd_data
);

  logic [itra_pkg::RADIX_W-1:0] mem_r [DEPTH];
  logic [itra_pkg::RADIX_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
